FILE: rtl/ccs_pkg.sv
// ccs_pkg: shared constants for the C comment stripper.
// No dependencies; used by the channel interfaces and c_comment_stripper.
`default_nettype none

package ccs_pkg;

  localparam int unsigned CH_W           = 8;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

endpackage

`default_nettype wire

FILE: rtl/ccs_if.sv
// ccs_in_if / ccs_out_if: valid/ready channels of the C comment stripper.
// Depends on ccs_pkg for the payload widths.
`default_nettype none

interface ccs_in_if;
  logic                     valid;
  logic                     ready;
  logic [ccs_pkg::CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ccs_out_if;
  logic                      valid;
  logic                      ready;
  logic [ccs_pkg::CH_W-1:0]  out_ch;
  logic                      last;
  logic                      unclosed_error;
  logic [ccs_pkg::POS_W-1:0] error_line;
  logic [ccs_pkg::POS_W-1:0] error_column;

  modport source (output valid, output out_ch, output last, output unclosed_error,
                  output error_line, output error_column, input ready);
  modport sink   (input valid, input out_ch, input last, input unclosed_error,
                  input error_line, input error_column, output ready);
endinterface

`default_nettype wire

FILE: rtl/c_comment_stripper.sv
// c_comment_stripper: byte-serial filter that drops C block and line comments.
// Depends on ccs_pkg and the channel interfaces in ccs_if.sv.
//
// Usage: source bytes enter on in_i, one request per byte; byte 0 ends the
// text. Filtered bytes leave on out_o; each input byte yields zero, one or two
// results, and the final result of a byte carries last. The end-of-text byte
// always yields a 0 terminator; if the text ended inside a block comment that
// terminator carries unclosed_error with the comment's line and column.
// A byte's results are written into the result queue when it is accepted; if the
// queue was empty, the first shows on out_o in the next cycle. Throughput: one byte
// per cycle while out_o drains one result per cycle; a byte that yields two results
// makes the three-entry result queue back up, and in_i.ready drops until it drains.
// in_i.ready is high whenever the queue holds at most one result, so it depends on
// no input in the same cycle. When the receiver stalls, results wait in the queue
// and input stops once two free entries are no longer guaranteed.
// Reset (rst_ni low, asynchronous) empties the queue and returns the scanner
// to normal text with all counters at zero; end of text does so too, but keeps the queue.
`default_nettype none

module c_comment_stripper #(
  parameter int unsigned COUNT_BITS = ccs_pkg::COUNT_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ccs_in_if.sink         in_i,
  ccs_out_if.source      out_o
);

  typedef enum logic [5:0] {
    MODE_NORMAL     = 6'b000001,
    MODE_SLASH      = 6'b000010,
    MODE_STRING     = 6'b000100,
    MODE_LINE       = 6'b001000,
    MODE_BLOCK      = 6'b010000,
    MODE_BLOCK_STAR = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [ccs_pkg::CH_W-1:0]  out_ch;
    logic                      last;
    logic                      unclosed_error;
    logic [ccs_pkg::POS_W-1:0] error_line;
    logic [ccs_pkg::POS_W-1:0] error_column;
  } res_t;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam int unsigned QDEPTH = 3;
  localparam cnt_t CLAMP_LIM = COUNT_BITS'(17'h0FFFF);

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [ccs_pkg::POS_W-1:0] clamp_pos(input cnt_t v);
    clamp_pos = (v > CLAMP_LIM) ? '1 : ccs_pkg::POS_W'(v);
  endfunction

  mode_e mode_q, mode_d;
  cnt_t  line_q, line_d, col_q, col_d, cline_q, cline_d, ccol_q, ccol_d;

  res_t       q_q [QDEPTH];
  res_t       q_d [QDEPTH];
  logic [1:0] count_q, count_d;

  logic       acc, pop;
  logic [ccs_pkg::CH_W-1:0] ch;

  // per-byte decode results
  logic [1:0] res_cnt;
  logic [ccs_pkg::CH_W-1:0] rb [2];
  logic       rerr;
  logic       nl_cnt, ended, set_cpos, plain;
  res_t       r0, r1;
  logic [1:0] base;

  assign ch  = in_i.ch;
  assign acc = in_i.valid & in_i.ready;
  assign pop = out_o.valid & out_o.ready;

  assign in_i.ready = (count_q <= 2'd1);

  always_comb begin
    res_cnt  = 2'd0;
    rb[0]    = ccs_pkg::CH_NUL;
    rb[1]    = ccs_pkg::CH_NUL;
    rerr     = 1'b0;
    nl_cnt   = 1'b0;
    ended    = 1'b0;
    set_cpos = 1'b0;
    plain    = 1'b0;
    mode_d   = mode_q;

    case (mode_q)
      MODE_SLASH: begin
        if (ch == ccs_pkg::CH_STAR) begin
          mode_d = MODE_BLOCK;
        end else if (ch == ccs_pkg::CH_SLASH) begin
          mode_d = MODE_LINE;
        end else begin
          rb[0]   = ccs_pkg::CH_SLASH;
          res_cnt = 2'd1;
          plain   = 1'b1;
        end
      end
      MODE_STRING: begin
        if (ch == ccs_pkg::CH_NUL) begin
          // close the open string before the terminator
          rb[0]   = ccs_pkg::CH_QUOTE;
          rb[1]   = ccs_pkg::CH_NUL;
          res_cnt = 2'd2;
          ended   = 1'b1;
        end else begin
          if (ch == ccs_pkg::CH_NL) begin
            nl_cnt = 1'b1;
          end else if (ch == ccs_pkg::CH_QUOTE) begin
            mode_d = MODE_NORMAL;
          end
          rb[0]   = ch;
          res_cnt = 2'd1;
        end
      end
      MODE_LINE: begin
        if (ch == ccs_pkg::CH_NUL) begin
          res_cnt = 2'd1;
          ended   = 1'b1;
        end else if (ch == ccs_pkg::CH_NL) begin
          rb[0]   = ccs_pkg::CH_NL;
          res_cnt = 2'd1;
          nl_cnt  = 1'b1;
          mode_d  = MODE_NORMAL;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (ch == ccs_pkg::CH_NUL) begin
          res_cnt = 2'd1;
          rerr    = 1'b1;
          ended   = 1'b1;
        end else if (ch == ccs_pkg::CH_NL) begin
          // newline kept but not counted inside a block comment
          rb[0]   = ccs_pkg::CH_NL;
          res_cnt = 2'd1;
          mode_d  = MODE_BLOCK;
        end else if (ch == ccs_pkg::CH_STAR) begin
          mode_d = MODE_BLOCK_STAR;
        end else if (ch == ccs_pkg::CH_SLASH && mode_q == MODE_BLOCK_STAR) begin
          rb[0]   = ccs_pkg::CH_NL;
          res_cnt = 2'd1;
          mode_d  = MODE_NORMAL;
        end else begin
          mode_d = MODE_BLOCK;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      mode_d = MODE_NORMAL;
      if (ch == ccs_pkg::CH_NUL) begin
        rb[res_cnt[0]] = ccs_pkg::CH_NUL;
        res_cnt        = res_cnt + 2'd1;
        ended          = 1'b1;
      end else if (ch == ccs_pkg::CH_QUOTE) begin
        rb[res_cnt[0]] = ch;
        res_cnt        = res_cnt + 2'd1;
        mode_d         = MODE_STRING;
      end else if (ch == ccs_pkg::CH_SLASH) begin
        set_cpos = 1'b1;
        mode_d   = MODE_SLASH;
      end else begin
        nl_cnt         = (ch == ccs_pkg::CH_NL);
        rb[res_cnt[0]] = ch;
        res_cnt        = res_cnt + 2'd1;
      end
    end
  end

  // only the terminator of an unclosed comment carries the error fields
  always_comb begin
    r0.out_ch         = rb[0];
    r0.last           = (res_cnt == 2'd1);
    r0.unclosed_error = rerr;
    r0.error_line     = rerr ? clamp_pos(cline_q) : '0;
    r0.error_column   = rerr ? clamp_pos(ccol_q) : '0;
    r1.out_ch         = rb[1];
    r1.last           = 1'b1;
    r1.unclosed_error = 1'b0;
    r1.error_line     = '0;
    r1.error_column   = '0;
  end

  always_comb begin
    line_d  = line_q;
    col_d   = col_q;
    cline_d = cline_q;
    ccol_d  = ccol_q;
    if (acc) begin
      if (ended) begin
        line_d  = '0;
        col_d   = '0;
        cline_d = '0;
        ccol_d  = '0;
      end else begin
        if (set_cpos) begin
          cline_d = sat_inc(line_q);
          ccol_d  = sat_inc(col_q);
        end
        if (nl_cnt) begin
          line_d = sat_inc(line_q);
          col_d  = '0;
        end else begin
          col_d = sat_inc(col_q);
        end
      end
    end
  end

  // result queue: head at entry 0, shift on pop, append up to two results
  always_comb begin
    base = pop ? count_q - 2'd1 : count_q;
    for (int i = 0; i < QDEPTH; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
    end
    if (acc && res_cnt != 2'd0) begin
      q_d[base] = r0;
    end
    if (acc && res_cnt == 2'd2) begin
      q_d[base + 2'd1] = r1;
    end
    count_d = base + (acc ? res_cnt : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      line_q  <= '0;
      col_q   <= '0;
      cline_q <= '0;
      ccol_q  <= '0;
      count_q <= 2'd0;
    end else begin
      if (acc) begin
        mode_q <= ended ? MODE_NORMAL : mode_d;
      end
      line_q  <= line_d;
      col_q   <= col_d;
      cline_q <= cline_d;
      ccol_q  <= ccol_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_o.valid          = (count_q != 2'd0);
  assign out_o.out_ch         = q_q[0].out_ch;
  assign out_o.last           = q_q[0].last;
  assign out_o.unclosed_error = q_q[0].unclosed_error;
  assign out_o.error_line     = q_q[0].error_line;
  assign out_o.error_column   = q_q[0].error_column;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QDEPTH))
    else $error("result queue over capacity");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && ended |=> mode_q == MODE_NORMAL && line_q == '0 && col_q == '0)
    else $error("end of text did not return scanner to start state");

  a_silent_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && res_cnt == 2'd0 && !pop |=> $stable(count_q))
    else $error("queue changed on a byte with no result");

  a_err_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.unclosed_error |->
      out_o.out_ch == ccs_pkg::CH_NUL && out_o.last)
    else $error("unclosed-comment flag on a non-terminator result");
`endif

endmodule

`default_nettype wire

FILE: tb/c_comment_stripper_tb.sv
// c_comment_stripper_tb: self-checking bench for the C comment stripper. Drives bytes
// through ccs_in_if and checks every result on ccs_out_if against a behavioral filter
// model or a typed row's own result. Depends on ccs_pkg, ccs_if.sv and c_comment_stripper.
`default_nettype none

module c_comment_stripper_tb;

  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned PRINT_CAP      = 40;

  typedef enum logic [2:0] {
    SCAN_TEXT, SCAN_SLASH, SCAN_STRING, SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR
  } scan_mode_e;

  typedef struct packed {
    logic [ccs_pkg::CH_W-1:0]  out_ch;
    logic                      last;
    logic                      unclosed;
    logic [ccs_pkg::POS_W-1:0] eline;
    logic [ccs_pkg::POS_W-1:0] ecol;
  } result_t;

  typedef struct {
    logic [ccs_pkg::CH_W-1:0] ch;
    bit                       typed;
    result_t                  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  c_comment_stripper u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter model state
  scan_mode_e                scan_mode;
  logic [ccs_pkg::POS_W-1:0] line_cnt, col_cnt, cmt_line, cmt_col;
  bit                        nl_seen, text_end;
  result_t                   byte_out[$];
  result_t                   pending_bytes[$];

  // sideband that travels with the request: typed expectation for table rows
  bit               row_typed;
  result_t          row_res;

  bit               idle_en;
  int unsigned      fail_cnt;
  int unsigned      quiet_cycles;
  int unsigned      random_items;

  function automatic logic [ccs_pkg::POS_W-1:0] bump(input logic [ccs_pkg::POS_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_scan();
    scan_mode = SCAN_TEXT;
    line_cnt  = '0;
    col_cnt   = '0;
    cmt_line  = '0;
    cmt_col   = '0;
  endfunction

  function automatic void emit(input logic [ccs_pkg::CH_W-1:0] c, input bit err);
    result_t r;
    r = '0;
    r.out_ch   = c;
    r.unclosed = err;
    if (err) begin
      r.eline = cmt_line;
      r.ecol  = cmt_col;
    end
    byte_out.push_back(r);
  endfunction

  function automatic void plain_char(input logic [ccs_pkg::CH_W-1:0] c,
                                     input logic [ccs_pkg::POS_W-1:0] col);
    if (c == ccs_pkg::CH_NUL) begin
      emit(ccs_pkg::CH_NUL, 1'b0);
      text_end = 1'b1;
    end else if (c == ccs_pkg::CH_QUOTE) begin
      emit(c, 1'b0);
      scan_mode = SCAN_STRING;
    end else if (c == ccs_pkg::CH_SLASH) begin
      // remember where a possible comment opens
      cmt_line  = bump(line_cnt);
      cmt_col   = bump(col);
      scan_mode = SCAN_SLASH;
    end else begin
      if (c == ccs_pkg::CH_NL) nl_seen = 1'b1;
      emit(c, 1'b0);
    end
  endfunction

  function automatic void filter_byte(input logic [ccs_pkg::CH_W-1:0] c);
    logic [ccs_pkg::POS_W-1:0] col;
    result_t                   tail;
    col      = col_cnt;
    nl_seen  = 1'b0;
    text_end = 1'b0;
    byte_out.delete();
    case (scan_mode)
      SCAN_SLASH: begin
        if (c == ccs_pkg::CH_STAR) begin
          scan_mode = SCAN_BLOCK;
        end else if (c == ccs_pkg::CH_SLASH) begin
          scan_mode = SCAN_LINE;
        end else begin
          emit(ccs_pkg::CH_SLASH, 1'b0);
          scan_mode = SCAN_TEXT;
          plain_char(c, col);
        end
      end
      SCAN_STRING: begin
        if (c == ccs_pkg::CH_NUL) begin
          emit(ccs_pkg::CH_QUOTE, 1'b0);
          emit(ccs_pkg::CH_NUL, 1'b0);
          text_end = 1'b1;
        end else begin
          if (c == ccs_pkg::CH_NL) nl_seen = 1'b1;
          else if (c == ccs_pkg::CH_QUOTE) scan_mode = SCAN_TEXT;
          emit(c, 1'b0);
        end
      end
      SCAN_LINE: begin
        if (c == ccs_pkg::CH_NUL) begin
          emit(ccs_pkg::CH_NUL, 1'b0);
          text_end = 1'b1;
        end else if (c == ccs_pkg::CH_NL) begin
          emit(ccs_pkg::CH_NL, 1'b0);
          nl_seen   = 1'b1;
          scan_mode = SCAN_TEXT;
        end
      end
      SCAN_BLOCK, SCAN_BLOCK_STAR: begin
        // newlines inside a block comment pass but are not counted
        if (c == ccs_pkg::CH_NUL) begin
          emit(ccs_pkg::CH_NUL, 1'b1);
          text_end = 1'b1;
        end else if (c == ccs_pkg::CH_NL) begin
          emit(ccs_pkg::CH_NL, 1'b0);
          scan_mode = SCAN_BLOCK;
        end else if (c == ccs_pkg::CH_STAR) begin
          scan_mode = SCAN_BLOCK_STAR;
        end else if (c == ccs_pkg::CH_SLASH && scan_mode == SCAN_BLOCK_STAR) begin
          emit(ccs_pkg::CH_NL, 1'b0);
          scan_mode = SCAN_TEXT;
        end else begin
          scan_mode = SCAN_BLOCK;
        end
      end
      default: begin
        scan_mode = SCAN_TEXT;
        plain_char(c, col);
      end
    endcase

    if (text_end) begin
      clear_scan();
    end else if (nl_seen) begin
      line_cnt = bump(line_cnt);
      col_cnt  = '0;
    end else begin
      col_cnt = bump(col_cnt);
    end

    if (byte_out.size() != 0) begin
      tail = byte_out.pop_back();
      tail.last = 1'b1;
      byte_out.push_back(tail);
    end
  endfunction

  function automatic void flag_field(input string field, input longint unsigned want,
                                     input longint unsigned got);
    fail_cnt++;
    if (fail_cnt <= PRINT_CAP)
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
  endfunction

  // result checking, model update on each accepted byte, and the watchdog
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_ch, out_if.last, out_if.unclosed_error,
                out_if.error_line, out_if.error_column};
        if (pending_bytes.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= PRINT_CAP)
            $display("%0t: unexpected result, expected none actual 0x%0h", $time, got);
        end else begin
          want = pending_bytes.pop_front();
          if (got.out_ch !== want.out_ch)     flag_field("out_ch", want.out_ch, got.out_ch);
          if (got.last !== want.last)         flag_field("last", want.last, got.last);
          if (got.unclosed !== want.unclosed)
            flag_field("unclosed_error", want.unclosed, got.unclosed);
          if (got.eline !== want.eline)       flag_field("error_line", want.eline, got.eline);
          if (got.ecol !== want.ecol)         flag_field("error_column", want.ecol, got.ecol);
        end
      end
      if (in_if.valid && in_if.ready) begin
        filter_byte(in_if.ch);
        if (row_typed) pending_bytes.push_back(row_res);
        else foreach (byte_out[i]) pending_bytes.push_back(byte_out[i]);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pending_bytes.size());
        $display("c_comment_stripper verification failed");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    int unsigned stall_left;
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [ccs_pkg::CH_W-1:0] c, input bit typed = 1'b0,
                           input result_t tres = '0);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    row_typed   <= typed;
    row_res     <= tres;
    do @(posedge clk_i); while (!in_if.ready);
    random_items++;
    gap = (idle_en && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until every outstanding result has drained
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ccs_pkg::CH_W-1:0] text_char();
    case ($urandom_range(0, 9))
      0:       return ccs_pkg::CH_NL;
      1:       return ccs_pkg::CH_STAR;
      2:       return ccs_pkg::CH_SLASH;
      3:       return ccs_pkg::CH_QUOTE;
      default: return ccs_pkg::CH_W'($urandom_range(1, 255));
    endcase
  endfunction

  // mostly well-formed C fragments with random content, plus some noise
  task automatic send_fragment();
    int unsigned              len;
    logic [ccs_pkg::CH_W-1:0] c;
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 11))
      0, 1, 2: repeat (len) send_byte(text_char());
      3, 4: begin
        send_byte(ccs_pkg::CH_QUOTE);
        repeat (len) begin
          do c = text_char(); while (c == ccs_pkg::CH_QUOTE);
          send_byte(c);
        end
        if ($urandom_range(0, 7) != 0) send_byte(ccs_pkg::CH_QUOTE);
      end
      5: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(ccs_pkg::CH_SLASH);
        repeat (len) begin
          do c = text_char(); while (c == ccs_pkg::CH_NL);
          send_byte(c);
        end
        if ($urandom_range(0, 7) != 0) send_byte(ccs_pkg::CH_NL);
      end
      6, 7: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(ccs_pkg::CH_STAR);
        repeat (len) send_byte(text_char());
        repeat ($urandom_range(1, 3)) send_byte(ccs_pkg::CH_STAR);
        if ($urandom_range(0, 7) != 0) send_byte(ccs_pkg::CH_SLASH);
      end
      8: begin
        send_byte(ccs_pkg::CH_SLASH);
        send_byte(ccs_pkg::CH_W'($urandom_range(1, 255)));
      end
      9:       send_byte(ccs_pkg::CH_W'($urandom_range(0, 255)));
      10:      send_byte(ccs_pkg::CH_NUL);
      default: send_byte(ccs_pkg::CH_NL);
    endcase
  endtask

  stim_row_t dir_rows[27];

  initial begin
    bit pressure_done;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.ch     <= ccs_pkg::CH_NUL;
    row_typed    <= 1'b0;
    row_res      <= '0;
    idle_en       = 1'b1;
    fail_cnt      = 0;
    quiet_cycles  = 0;
    random_items  = 0;
    pressure_done = 1'b0;
    clear_scan();

    dir_rows = '{
      '{8'hFF,             1'b1, '{8'hFF, 1'b1, 1'b0, 16'd0, 16'd0}},
      '{8'h01,             1'b1, '{8'h01, 1'b1, 1'b0, 16'd0, 16'd0}},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},  // held slash
      '{"b",               1'b0, '0},  // releases the slash
      '{ccs_pkg::CH_QUOTE, 1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_NL,    1'b0, '0},
      '{ccs_pkg::CH_QUOTE, 1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{8'h80,             1'b0, '0},
      '{ccs_pkg::CH_NL,    1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_STAR,  1'b0, '0},
      '{ccs_pkg::CH_NL,    1'b0, '0},
      '{ccs_pkg::CH_STAR,  1'b0, '0},
      '{ccs_pkg::CH_STAR,  1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_NUL,   1'b0, '0},  // end right after a held slash
      '{ccs_pkg::CH_QUOTE, 1'b0, '0},
      '{ccs_pkg::CH_NUL,   1'b0, '0},  // end inside a string
      '{" ",               1'b0, '0},
      '{ccs_pkg::CH_SLASH, 1'b0, '0},
      '{ccs_pkg::CH_STAR,  1'b0, '0},
      '{ccs_pkg::CH_NUL,   1'b1, '{ccs_pkg::CH_NUL, 1'b1, 1'b1, 16'd1, 16'd2}},
      '{ccs_pkg::CH_NUL,   1'b1, '{ccs_pkg::CH_NUL, 1'b1, 1'b0, 16'd0, 16'd0}}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
      if (!pressure_done && random_items >= RANDOM_ITEMS / 2) begin
        drain_results();
        pressure_done = 1'b1;
      end
      send_fragment();
    end
    idle_en = 1'b1;
    send_byte(ccs_pkg::CH_NUL);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_bytes.size());
    end
    if (fail_cnt == 0) begin
      $display("c_comment_stripper verification clean");
    end else begin
      $display("c_comment_stripper verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/ccs_pkg.sv
rtl/ccs_if.sv
rtl/c_comment_stripper.sv
tb/c_comment_stripper_tb.sv
